// File: src/gdod_pkg.sv
`timescale 1ns / 1ps

package gdod_pkg;

  // Widths of the internal day serials and of the year unit
  localparam int SER_W    = 26;
  localparam int BY_W     = 24;
  localparam int YW       = 15;
  localparam int REM_W    = 9;
  localparam int CNT_W    = 22;
  localparam int PROD_W   = 28;

  // floor(x / 100) = (x * RECIP) >> RECIP_SH for x below 43690
  localparam int RECIP    = 5243;
  localparam int RECIP_SH = 19;

  // Cycles from loading the year unit to its result being usable
  localparam logic [1:0] YU_LAT = 2'd2;

  // Year unit source codes
  localparam int YU_SEL_W = 2;
  localparam logic [YU_SEL_W-1:0] YU_Y1   = 2'd0;
  localparam logic [YU_SEL_W-1:0] YU_Y2   = 2'd1;
  localparam logic [YU_SEL_W-1:0] YU_CAND = 2'd2;
  localparam logic [YU_SEL_W-1:0] YU_SRCH = 2'd3;

  typedef struct packed {
    logic                load;
    logic                yu_load;
    logic [YU_SEL_W-1:0] yu_sel;
    logic                ser1_wr;
    logic                ser2_wr;
    logic                chk_wr;
    logic                add_wr;
    logic                rng_wr;
    logic                sr_step;
    logic                rem_wr;
    logic                mon_step;
    logic                res_wr;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic s_bad;
    logic bit_last;
    logic mon_done;
  } sts_t;

  // Days in the year before the first of month m, common year
  function automatic logic [REM_W-1:0] days_before(input logic [3:0] m);
    logic [REM_W-1:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Length of month m
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    case (m)
      4'd2:    r = leap ? 5'd29 : 5'd28;
      4'd4:    r = 5'd30;
      4'd6:    r = 5'd30;
      4'd9:    r = 5'd30;
      4'd11:   r = 5'd30;
      default: r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

// File: src/gdod_dp.sv
`timescale 1ns / 1ps

module gdod_dp import gdod_pkg::*; #(
  parameter int YEAR_MAX = 9999
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic               in_mode,
  input  logic [4:0]         in_day,
  input  logic [3:0]         in_month,
  input  logic [13:0]        in_year,
  input  logic signed [16:0] in_offset_days,
  input  logic [4:0]         in_other_day,
  input  logic [3:0]         in_other_month,
  input  logic [13:0]        in_other_year,
  output logic [4:0]         out_day,
  output logic [3:0]         out_month,
  output logic [13:0]        out_year,
  output logic [21:0]        out_day_count,
  output logic               out_error
);

  // First serial past the last day of YEAR_MAX
  localparam int YEAR_LIM = YEAR_MAX + 1;
  localparam int LIM_INT  = 365 * YEAR_LIM + (YEAR_LIM + 3) / 4
                            - (YEAR_LIM + 99) / 100 + (YEAR_LIM + 399) / 400;
  localparam logic signed [SER_W-1:0] LIM = SER_W'(LIM_INT);

  logic               mode_r;
  logic [4:0]         d1_r, d2_r;
  logic [3:0]         m1_r, m2_r;
  logic [13:0]        y1_r, y2_r;
  logic signed [16:0] off_r;

  logic [YW-1:0]      yu_y_r, yu_y_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [BY_W-1:0]    by_r, by_nxt;
  logic               leap_r, leap_nxt;
  logic [YW:0]        y99, y3;
  logic [8:0]         q100;
  logic [9:0]         q100p3;
  logic [15:0]        q100x100;
  logic               exact100;

  logic signed [SER_W-1:0] ser1_r, ser2_r, s_r;
  logic [SER_W-1:0]        ser_u;
  logic signed [SER_W-1:0] by_s, s_nxt, diff, rem_diff;
  logic [4:0]              sel_d;
  logic [3:0]              sel_m, mc;
  logic                    adj;

  logic               err_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [YW-1:0]      srch_y_r, bit_r;
  logic [REM_W-1:0]   rem_r;
  logic [3:0]         mon_r;
  logic [4:0]         mlen;
  logic               bad1, bad2;

  logic [4:0]         out_day_r;
  logic [3:0]         out_month_r;
  logic [13:0]        out_year_r;
  logic [CNT_W-1:0]   out_day_count_r;
  logic               out_error_r;

  // Capture the input word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      d1_r   <= in_day;
      m1_r   <= in_month;
      y1_r   <= in_year;
      off_r  <= in_offset_days;
      d2_r   <= in_other_day;
      m2_r   <= in_other_month;
      y2_r   <= in_other_year;
    end
  end

  // Year unit: days before 1 January of yu_y_r, and its leap flag
  always_comb begin
    case (cmd.yu_sel)
      YU_Y1:   yu_y_nxt = {1'b0, y1_r};
      YU_Y2:   yu_y_nxt = {1'b0, y2_r};
      YU_CAND: yu_y_nxt = srch_y_r | bit_r;
      YU_SRCH: yu_y_nxt = srch_y_r;
      default: yu_y_nxt = srch_y_r;
    endcase
  end

  assign y99      = {1'b0, yu_y_r} + (YW+1)'(99);
  assign prod_nxt = PROD_W'(y99) * PROD_W'(RECIP);
  assign q100     = prod_r[PROD_W-1:RECIP_SH];
  assign q100p3   = {1'b0, q100} + 10'd3;
  assign y3       = {1'b0, yu_y_r} + (YW+1)'(3);
  assign q100x100 = {q100, 6'b0} + {1'b0, q100, 5'b0} + {4'b0, q100, 2'b0};
  assign exact100 = (q100x100 == {1'b0, yu_y_r});
  assign by_nxt   = BY_W'(yu_y_r) * BY_W'(365) + BY_W'(y3[YW:2])
                    - BY_W'(q100) + BY_W'(q100p3[9:2]);
  assign leap_nxt = (yu_y_r[1:0] == 2'd0) && (!exact100 || (q100[1:0] == 2'd0));

  always_ff @(posedge clk) begin
    if (cmd.yu_load) yu_y_r <= yu_y_nxt;
    prod_r <= prod_nxt;
    by_r   <= by_nxt;
    leap_r <= leap_nxt;
  end

  // Serial of a date from the year unit result
  assign sel_d = cmd.ser2_wr ? d2_r : d1_r;
  assign sel_m = cmd.ser2_wr ? m2_r : m1_r;
  assign mc    = (sel_m == 4'd0) ? 4'd1 : ((sel_m > 4'd12) ? 4'd12 : sel_m);
  assign adj   = leap_r && (mc > 4'd2);
  assign ser_u = SER_W'(by_r) + SER_W'(days_before(mc)) + SER_W'(adj)
                 + SER_W'(sel_d) - SER_W'(1);
  assign by_s  = $signed({2'b00, by_r});

  assign s_nxt    = ser1_r + {{(SER_W-17){off_r[16]}}, off_r};
  assign diff     = ser1_r - ser2_r;
  assign rem_diff = s_r - by_s;
  assign bad1     = ser1_r[SER_W-1] || (ser1_r >= LIM);
  assign bad2     = ser2_r[SER_W-1] || (ser2_r >= LIM);
  assign mlen     = month_len(mon_r, leap_r);

  always_ff @(posedge clk) begin
    if (cmd.ser1_wr) ser1_r <= $signed(ser_u);
    if (cmd.ser2_wr) ser2_r <= $signed(ser_u);
    if (cmd.add_wr)  s_r    <= s_nxt;
    if (cmd.load) begin
      err_r <= 1'b0;
    end else if (cmd.chk_wr) begin
      err_r <= bad1 || bad2 || (ser2_r > ser1_r);
    end else if (cmd.rng_wr) begin
      err_r <= sts.s_bad;
    end
    if (cmd.chk_wr) cnt_r <= diff[CNT_W-1:0];
    // Walk the months of the found year
    if (cmd.rem_wr) begin
      rem_r <= rem_diff[REM_W-1:0];
      mon_r <= 4'd1;
    end else if (cmd.mon_step) begin
      rem_r <= rem_r - REM_W'(mlen);
      mon_r <= mon_r + 4'd1;
    end
  end

  // Bit-by-bit search for the last year starting on or before s_r
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= '0;
    end else if (cmd.rng_wr) begin
      bit_r <= {1'b1, {(YW-1){1'b0}}};
    end else if (cmd.sr_step) begin
      bit_r <= bit_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rng_wr) begin
      srch_y_r <= '0;
    end else if (cmd.sr_step && (by_s <= s_r)) begin
      srch_y_r <= yu_y_r;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.res_wr) begin
      out_error_r <= err_r;
      if (err_r) begin
        out_day_r       <= '0;
        out_month_r     <= '0;
        out_year_r      <= '0;
        out_day_count_r <= '0;
      end else if (mode_r) begin
        out_day_r       <= '0;
        out_month_r     <= '0;
        out_year_r      <= '0;
        out_day_count_r <= cnt_r;
      end else begin
        out_day_r       <= rem_r[4:0] + 5'd1;
        out_month_r     <= mon_r;
        out_year_r      <= srch_y_r[13:0];
        out_day_count_r <= '0;
      end
    end
  end

  assign sts.mode     = mode_r;
  assign sts.s_bad    = s_r[SER_W-1] || (s_r >= LIM);
  assign sts.bit_last = bit_r[0];
  assign sts.mon_done = (mon_r == 4'd12) || (rem_r < REM_W'(mlen));

  assign out_day       = out_day_r;
  assign out_month     = out_month_r;
  assign out_year      = out_year_r;
  assign out_day_count = out_day_count_r;
  assign out_error     = out_error_r;

  a_bit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(bit_r))
    else $error("search bit mask not one-hot");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_wr && err_r |=> out_error_r && out_day_r == '0 && out_month_r == '0
                            && out_year_r == '0 && out_day_count_r == '0)
    else $error("error word carries non-zero fields");

  a_date_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_wr && !err_r && !mode_r |=> out_month_r >= 4'd1 && out_month_r <= 4'd12
                                        && out_day_r != 5'd0)
    else $error("shifted date out of calendar range");

endmodule

// File: src/gdod_ctrl.sv
`timescale 1ns / 1ps

module gdod_ctrl import gdod_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_S1_LD  = 4'd1;
  localparam logic [3:0] ST_S1_SER = 4'd2;
  localparam logic [3:0] ST_S2_LD  = 4'd3;
  localparam logic [3:0] ST_S2_SER = 4'd4;
  localparam logic [3:0] ST_CHK    = 4'd5;
  localparam logic [3:0] ST_ADD    = 4'd6;
  localparam logic [3:0] ST_RNG    = 4'd7;
  localparam logic [3:0] ST_SR_LD  = 4'd8;
  localparam logic [3:0] ST_SR_DEC = 4'd9;
  localparam logic [3:0] ST_FN_LD  = 4'd10;
  localparam logic [3:0] ST_FN_REM = 4'd11;
  localparam logic [3:0] ST_MON    = 4'd12;
  localparam logic [3:0] ST_DONE   = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic [1:0] wait_r, wait_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Sequence the datapath
  always_comb begin
    state_nxt = state_r;
    wait_nxt  = wait_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_S1_LD;
        end
      end
      ST_S1_LD: begin
        cmd.yu_load = 1'b1;
        cmd.yu_sel  = YU_Y1;
        wait_nxt    = YU_LAT;
        state_nxt   = ST_S1_SER;
      end
      ST_S1_SER: begin
        if (wait_r != 2'd0) begin
          wait_nxt = wait_r - 2'd1;
        end else begin
          cmd.ser1_wr = 1'b1;
          state_nxt   = sts.mode ? ST_S2_LD : ST_ADD;
        end
      end
      ST_S2_LD: begin
        cmd.yu_load = 1'b1;
        cmd.yu_sel  = YU_Y2;
        wait_nxt    = YU_LAT;
        state_nxt   = ST_S2_SER;
      end
      ST_S2_SER: begin
        if (wait_r != 2'd0) begin
          wait_nxt = wait_r - 2'd1;
        end else begin
          cmd.ser2_wr = 1'b1;
          state_nxt   = ST_CHK;
        end
      end
      ST_CHK: begin
        cmd.chk_wr = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_ADD: begin
        cmd.add_wr = 1'b1;
        state_nxt  = ST_RNG;
      end
      ST_RNG: begin
        cmd.rng_wr = 1'b1;
        state_nxt  = sts.s_bad ? ST_DONE : ST_SR_LD;
      end
      ST_SR_LD: begin
        cmd.yu_load = 1'b1;
        cmd.yu_sel  = YU_CAND;
        wait_nxt    = YU_LAT;
        state_nxt   = ST_SR_DEC;
      end
      ST_SR_DEC: begin
        if (wait_r != 2'd0) begin
          wait_nxt = wait_r - 2'd1;
        end else begin
          cmd.sr_step = 1'b1;
          state_nxt   = sts.bit_last ? ST_FN_LD : ST_SR_LD;
        end
      end
      ST_FN_LD: begin
        cmd.yu_load = 1'b1;
        cmd.yu_sel  = YU_SRCH;
        wait_nxt    = YU_LAT;
        state_nxt   = ST_FN_REM;
      end
      ST_FN_REM: begin
        if (wait_r != 2'd0) begin
          wait_nxt = wait_r - 2'd1;
        end else begin
          cmd.rem_wr = 1'b1;
          state_nxt  = ST_MON;
        end
      end
      ST_MON: begin
        if (sts.mon_done) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.mon_step = 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.res_wr = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold the result word until taken
  always_comb begin
    if (cmd.res_wr) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wait_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wait_r      <= wait_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_S1_LD && !in_ready)
    else $error("accepted word did not start the sequence");

  a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && (!out_valid_r || out_ready) |=> out_valid_r && state_r == ST_IDLE)
    else $error("finished word not placed in the result register");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r)
    else $error("result word dropped before it was taken");

endmodule

// File: src/gregorian_date_offset_and_difference.sv
// Channel  | Handshake              | Payload
// ---------+------------------------+------------------------------------------------
// input    | in_valid / in_ready    | in_mode, in_day, in_month, in_year,
//          |                        | in_offset_days, in_other_day/month/year
// result   | out_valid / out_ready  | out_day, out_month, out_year, out_day_count,
//          |                        | out_error
//
// One word at a time. Shift mode passes 15 trial years through the three-stage
// days-before-year unit (yu_y_r, prod_r, by_r), then steps through the months.
// A new word is taken once the previous one has reached the result register.
// Reset (rst_n low, synchronous) empties the result register and idles the sequencer.
`timescale 1ns / 1ps

module gregorian_date_offset_and_difference import gdod_pkg::*; #(
  parameter int YEAR_MAX = 9999
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  logic [4:0]         in_day,
  input  logic [3:0]         in_month,
  input  logic [13:0]        in_year,
  input  logic signed [16:0] in_offset_days,
  input  logic [4:0]         in_other_day,
  input  logic [3:0]         in_other_month,
  input  logic [13:0]        in_other_year,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [4:0]         out_day,
  output logic [3:0]         out_month,
  output logic [13:0]        out_year,
  output logic [21:0]        out_day_count,
  output logic               out_error
);

  cmd_t cmd;
  sts_t sts;

  gdod_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gdod_dp #(
    .YEAR_MAX (YEAR_MAX)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_mode        (in_mode),
    .in_day         (in_day),
    .in_month       (in_month),
    .in_year        (in_year),
    .in_offset_days (in_offset_days),
    .in_other_day   (in_other_day),
    .in_other_month (in_other_month),
    .in_other_year  (in_other_year),
    .out_day        (out_day),
    .out_month      (out_month),
    .out_year       (out_year),
    .out_day_count  (out_day_count),
    .out_error      (out_error)
  );

endmodule

// File: sim/gdod_date_checker.sv
`timescale 1ns / 1ps

module gdod_date_checker #(
  parameter int YEAR_MAX = 9999
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_mode,
  input  logic [4:0]         in_day,
  input  logic [3:0]         in_month,
  input  logic [13:0]        in_year,
  input  logic signed [16:0] in_offset_days,
  input  logic [4:0]         in_other_day,
  input  logic [3:0]         in_other_month,
  input  logic [13:0]        in_other_year,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [4:0]         out_day,
  input  logic [3:0]         out_month,
  input  logic [13:0]        out_year,
  input  logic [21:0]        out_day_count,
  input  logic               out_error,
  output int                 mismatches,
  output int                 outstanding
);

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [21:0] count;
    logic        error;
  } date_result_t;

  date_result_t awaited_q[$];
  int           fail_cnt = 0;

  assign mismatches = fail_cnt;

  // Days from 1 January of year 0 to 1 January of year y
  function automatic longint days_to_year(input longint y);
    return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
  endfunction

  function automatic bit is_leap(input longint y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic longint days_in_month(input longint m, input longint y);
    case (m)
      2:           return is_leap(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  // Day serial of a date; clamp the month, let the day carry over freely
  function automatic longint day_serial(input logic [4:0] d, input logic [3:0] m,
                                        input logic [13:0] y);
    longint mm;
    longint yy;
    longint s;
    longint k;
    mm = m;
    if (mm < 1) mm = 1;
    if (mm > 12) mm = 12;
    yy = y;
    s  = days_to_year(yy);
    for (k = 1; k < mm; k++) s += days_in_month(k, yy);
    return s + longint'(d) - 1;
  endfunction

  // Work out the shifted date or the day count for one input word
  function automatic date_result_t predict_date_result(
    input logic               mode,
    input logic [4:0]         d1,
    input logic [3:0]         m1,
    input logic [13:0]        y1,
    input logic signed [16:0] offset,
    input logic [4:0]         d2,
    input logic [3:0]         m2,
    input logic [13:0]        y2
  );
    date_result_t r;
    longint       first;
    longint       second;
    longint       last_day;
    longint       s;
    longint       off;
    longint       yy;
    longint       mm;
    longint       rem;
    r        = '0;
    last_day = days_to_year(longint'(YEAR_MAX) + 1);
    first    = day_serial(d1, m1, y1);
    if (mode == 1'b0) begin
      off = offset;
      s   = first + off;
      if (s < 0 || s >= last_day) begin
        r.error = 1'b1;
      end else begin
        yy = (s * 400) / 146097;
        while (yy > 0 && days_to_year(yy) > s) yy--;
        while (days_to_year(yy + 1) <= s) yy++;
        rem = s - days_to_year(yy);
        mm  = 1;
        while (mm < 12 && rem >= days_in_month(mm, yy)) begin
          rem -= days_in_month(mm, yy);
          mm++;
        end
        r.day   = 5'(rem + 1);
        r.month = 4'(mm);
        r.year  = 14'(yy);
      end
    end else begin
      second = day_serial(d2, m2, y2);
      if (first < 0 || first >= last_day || second < 0 || second >= last_day ||
          second > first) begin
        r.error = 1'b1;
      end else begin
        r.count = 22'(first - second);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_cnt++;
  endtask

  // Queue a prediction per accepted input word, compare each result word
  always @(posedge clk) begin : watch_words
    date_result_t want;
    if (!rst_n) begin
      awaited_q.delete();
    end else begin
      if (in_valid && in_ready)
        awaited_q.push_back(predict_date_result(in_mode, in_day, in_month, in_year,
                                                in_offset_days, in_other_day,
                                                in_other_month, in_other_year));
      if (out_valid && out_ready) begin
        if (awaited_q.size() == 0) begin
          report_mismatch("result word with nothing awaited");
        end else begin
          want = awaited_q.pop_front();
          if (out_day !== want.day)
            report_mismatch($sformatf("day got %0d want %0d", out_day, want.day));
          if (out_month !== want.month)
            report_mismatch($sformatf("month got %0d want %0d", out_month, want.month));
          if (out_year !== want.year)
            report_mismatch($sformatf("year got %0d want %0d", out_year, want.year));
          if (out_day_count !== want.count)
            report_mismatch($sformatf("day_count got %0d want %0d",
                                      out_day_count, want.count));
          if (out_error !== want.error)
            report_mismatch($sformatf("error got %0b want %0b", out_error, want.error));
        end
      end
    end
    outstanding <= awaited_q.size();
  end

endmodule

// File: sim/tb_gregorian_date_offset_and_difference.sv
`timescale 1ns / 1ps

module tb_gregorian_date_offset_and_difference;

  localparam int YEAR_MAX    = 9999;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int RAND_WORDS  = 265;

  typedef struct packed {
    logic               mode;
    logic [4:0]         day;
    logic [3:0]         month;
    logic [13:0]        year;
    logic signed [16:0] offset;
    logic [4:0]         other_day;
    logic [3:0]         other_month;
    logic [13:0]        other_year;
  } date_word_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_mode = 1'b0;
  logic [4:0]         in_day = '0;
  logic [3:0]         in_month = '0;
  logic [13:0]        in_year = '0;
  logic signed [16:0] in_offset_days = '0;
  logic [4:0]         in_other_day = '0;
  logic [3:0]         in_other_month = '0;
  logic [13:0]        in_other_year = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [4:0]         out_day;
  logic [3:0]         out_month;
  logic [13:0]        out_year;
  logic [21:0]        out_day_count;
  logic               out_error;
  int                 mismatches;
  int                 outstanding;

  // Receiver hold-off and quiet-period control
  logic calm = 1'b0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   cycles = 0;

  gregorian_date_offset_and_difference #(.YEAR_MAX(YEAR_MAX)) DUT (.*);

  gdod_date_checker #(.YEAR_MAX(YEAR_MAX)) u_checker (.*);

  always #10 clk = ~clk;

  // Abandon a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 34);
    end
  end

  function automatic date_word_t make_word(input logic mode, input int d, input int m,
                                           input int y, input int off, input int od,
                                           input int om, input int oy);
    date_word_t w;
    w.mode        = mode;
    w.day         = 5'(d);
    w.month       = 4'(m);
    w.year        = 14'(y);
    w.offset      = 17'(off);
    w.other_day   = 5'(od);
    w.other_month = 4'(om);
    w.other_year  = 14'(oy);
    return w;
  endfunction

  // Mostly in-range years, with the edges and the whole 14-bit field now and then
  function automatic logic [13:0] pick_year();
    case ($urandom_range(0, 9))
      0:       return 14'($urandom_range(0, 3));
      1:       return 14'($urandom_range(YEAR_MAX - 3, YEAR_MAX));
      2:       return 14'($urandom_range(0, 16383));
      default: return 14'($urandom_range(0, YEAR_MAX));
    endcase
  endfunction

  function automatic date_word_t random_word();
    date_word_t w;
    int         gap;
    w.mode  = 1'($urandom_range(0, 1));
    w.year  = pick_year();
    w.month = 4'($urandom_range(1, 12));
    w.day   = 5'($urandom_range(1, ($urandom_range(0, 3) == 0) ? 31 : 28));
    // Occasionally a malformed date over the full field ranges
    if ($urandom_range(0, 5) == 0) begin
      w.day   = 5'($urandom_range(0, 31));
      w.month = 4'($urandom_range(0, 15));
      w.year  = 14'($urandom_range(0, 16383));
    end
    case ($urandom_range(0, 3))
      0:       w.offset = 17'(int'($urandom_range(0, 800)) - 400);
      1:       w.offset = 17'(int'($urandom_range(0, 10000)) - 5000);
      default: w.offset = 17'($urandom_range(0, 17'h1FFFF));
    endcase
    w.other_day   = 5'($urandom_range(1, 31));
    w.other_month = 4'($urandom_range(1, 12));
    if (w.mode && $urandom_range(0, 3) != 0) begin
      // Other year at or before the first one, half the time close behind it
      gap = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, YEAR_MAX);
      if (gap > w.year) gap = w.year;
      w.other_year = 14'(w.year - gap);
    end else begin
      w.other_day   = 5'($urandom_range(0, 31));
      w.other_month = 4'($urandom_range(0, 15));
      w.other_year  = pick_year();
    end
    return w;
  endfunction

  // Offer one word, hold it until accepted
  task automatic send_word(input date_word_t w);
    if (!calm)
      while ($urandom_range(0, 99) < 34) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid       <= 1'b1;
    in_mode        <= w.mode;
    in_day         <= w.day;
    in_month       <= w.month;
    in_year        <= w.year;
    in_offset_days <= w.offset;
    in_other_day   <= w.other_day;
    in_other_month <= w.other_month;
    in_other_year  <= w.other_year;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop offering until every awaited result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: range edges, leap rules, carries, clamped months
    send_word(make_word(0, 1, 1, 0, 0, 1, 1, 0));
    send_word(make_word(0, 1, 1, 0, -1, 31, 15, 16383));
    send_word(make_word(0, 31, 12, 9999, 1, 0, 0, 0));
    send_word(make_word(0, 31, 12, 9999, 0, 5, 5, 5));
    send_word(make_word(0, 28, 2, 2000, 1, 1, 1, 1));
    send_word(make_word(0, 28, 2, 1900, 1, 1, 1, 1));
    send_word(make_word(0, 28, 2, 2024, 1, 1, 1, 1));
    send_word(make_word(0, 15, 6, 5000, 65535, 1, 1, 1));
    send_word(make_word(0, 15, 6, 5000, -65536, 1, 1, 1));
    send_word(make_word(0, 0, 3, 2001, 0, 1, 1, 1));
    send_word(make_word(0, 31, 2, 2001, 0, 1, 1, 1));
    send_word(make_word(0, 10, 0, 100, 5, 1, 1, 1));
    send_word(make_word(0, 31, 15, 10, 0, 1, 1, 1));
    send_word(make_word(0, 31, 15, 16383, -65536, 1, 1, 1));
    send_word(make_word(0, 1, 1, 10000, -1, 1, 1, 1));
    send_word(make_word(0, 0, 1, 0, 1, 1, 1, 1));
    send_word(make_word(1, 12, 7, 1984, 0, 12, 7, 1984));
    send_word(make_word(1, 31, 12, 9999, 0, 1, 1, 0));
    send_word(make_word(1, 1, 1, 2000, 0, 2, 1, 2000));
    send_word(make_word(1, 1, 1, 10000, 0, 1, 1, 9999));
    send_word(make_word(1, 5, 5, 5, 0, 0, 1, 0));
    send_word(make_word(1, 1, 3, 2000, 0, 28, 2, 2000));
    send_word(make_word(1, 31, 15, 16383, 65535, 0, 0, 0));
    send_word(make_word(1, 0, 0, 0, -1, 31, 15, 16383));
    send_word(make_word(1, 1, 3, 1900, 0, 28, 2, 1900));

    // Random words with a quiet stretch, a receiver hold-off and a drain pause
    for (int i = 0; i < RAND_WORDS; i++) begin
      if (i == 100) calm <= 1'b1;
      if (i == 160) calm <= 1'b0;
      if (i == 200) hold_req <= 1'b1;
      if (i == 250) drain();
      send_word(random_word());
    end

    drain();
    repeat (120) @(posedge clk);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
